@@ hw/rtl/jtpr_pkg.sv @@
// Shared types, widths and register codes for the three-point relaxation block.
`default_nettype none
package jtpr_pkg;

	localparam int VAL_W       = 32;
	localparam int TOL_W       = 31;
	localparam int CNT_W       = 16;
	localparam int CFG_IDX_W   = 4;
	localparam int CFG_DATA_W  = 32;
	localparam int SUM_W       = 34;
	localparam int CHUNK_W     = 17;
	localparam int RECIP_W     = 33;
	localparam int PART_W      = CHUNK_W + RECIP_W;
	localparam int PROD_W      = 66;
	localparam int RECIP_SHIFT = 34;
	localparam int DIV_STEPS   = 2;
	localparam int STEP_W      = 1;

	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic [TOL_W-1:0]        tol_t;
	typedef logic [CNT_W-1:0]        cnt_t;
	typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0]   cfg_data_t;
	typedef logic signed [SUM_W-1:0] sum_t;

	localparam cfg_idx_t REG_TOLERANCE = cfg_idx_t'(0);
	localparam cfg_idx_t REG_SWEEP_CAP = cfg_idx_t'(1);

	localparam tol_t TOL_RESET   = tol_t'(13107);
	localparam cnt_t SWEEP_LIMIT = cnt_t'(16'hFFFF);

	// One third scaled by 2^34, rounded up: exact for magnitudes below 2^33.
	localparam logic [RECIP_W-1:0] RECIP_3 = 33'h1_5555_5556;

endpackage
`default_nettype wire

@@ hw/rtl/jacobi_three_point_relaxation_top.sv @@
// Three-point Jacobi relaxation of a Q16.16 vector with a shared divide-by-three unit.
`default_nettype none
//
// Channel   Direction  Handshake             Word
// --------  ---------  --------------------  ------------------------------------------
// in        sink       in_valid / in_stall   current_value, old_value, last_element
// out       source     out_valid / out_stall result_value, sweeps_done, capped,
//                                            last_result
// cfg       sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// Sequence: loading accepts one word per cycle. Each sweep opens, reads each
// position in turn, updates each interior element and closes; the divide by
// three is a reciprocal multiply in two 17-bit passes on one shared multiplier,
// plus read, sum, sign, write and compare steps. Emission reads, loads and
// holds each word, waiting out any stall time.
// Reset: arst_n resets the sequencer, counters, flags and config registers;
// the element memory holds no reset value and is always written before read.
// Stalls: in_stall is high from the final word of a vector until the last result
// leaves; out_valid holds with a stable word until out_stall drops.
//
module jacobi_three_point_relaxation_top #(
	parameter int MAX_LENGTH = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,

	input  wire logic                in_valid,
	output      logic                in_stall,
	input  wire jtpr_pkg::val_t      current_value,
	input  wire jtpr_pkg::val_t      old_value,
	input  wire logic                last_element,

	output      logic                out_valid,
	input  wire logic                out_stall,
	output      jtpr_pkg::val_t      result_value,
	output      jtpr_pkg::cnt_t      sweeps_done,
	output      logic                capped,
	output      logic                last_result,

	input  wire logic                cfg_valid,
	output      logic                cfg_ready,
	input  wire jtpr_pkg::cfg_idx_t  cfg_index,
	input  wire jtpr_pkg::cfg_data_t cfg_data
);
	import jtpr_pkg::*;

	localparam int AW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
	localparam int IW = AW + 1;

	// Sequencer codes
	localparam logic [3:0] ST_LOAD     = 4'd0;
	localparam logic [3:0] ST_SW_START = 4'd1;
	localparam logic [3:0] ST_RD       = 4'd2;
	localparam logic [3:0] ST_LATCH    = 4'd3;
	localparam logic [3:0] ST_NEG      = 4'd4;
	localparam logic [3:0] ST_DIV      = 4'd5;
	localparam logic [3:0] ST_FIN      = 4'd6;
	localparam logic [3:0] ST_CMP      = 4'd7;
	localparam logic [3:0] ST_SW_END   = 4'd8;
	localparam logic [3:0] ST_OUT_RD   = 4'd9;
	localparam logic [3:0] ST_OUT_LD   = 4'd10;
	localparam logic [3:0] ST_OUT_HOLD = 4'd11;

	logic [3:0]       state_q;
	logic [AW-1:0]    pos_q;        // load position
	logic [AW-1:0]    last_idx_q;   // index of final element
	logic [AW-1:0]    idx_q;        // sweep / emission address
	val_t             old_first_q;  // boundary at position 0
	val_t             old_last_q;   // boundary at the final position
	val_t             prev_q;       // window: element left of the most recent one
	val_t             cent_q;       // window: most recent element
	sum_t             sum_q;
	logic [SUM_W-1:0] mag_q;        // dividend magnitude, consumed from the top
	logic [PROD_W-1:0] acc_q;       // magnitude times the scaled reciprocal
	logic             neg_q;
	logic [STEP_W-1:0] step_q;
	val_t             after_q;
	logic             over_q;
	cnt_t             cnt_q;
	logic             capped_q;
	tol_t             tol_q;
	cnt_t             cap_q;
	val_t             result_q;
	logic             out_valid_q;
	logic             last_q;

	// Element memory: one write port, one registered read port
	val_t             cur_mem [MAX_LENGTH];
	val_t             rdata_q;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	val_t             mem_wdata;

	logic             in_acc;
	logic             load_final;
	val_t             elem;
	sum_t             sum_next;
	logic [PART_W-1:0] part;
	logic [PROD_W-1:0] acc_next;
	val_t             quot;
	val_t             after;
	sum_t             change;
	sum_t             tol_pos;
	sum_t             tol_neg;
	cnt_t             cnt_next;
	cnt_t             limit;

	assign in_stall     = (state_q != ST_LOAD);
	assign in_acc       = in_valid && !in_stall;
	assign load_final   = last_element || (pos_q == AW'(MAX_LENGTH - 1));
	assign cfg_ready    = 1'b1;

	assign out_valid    = out_valid_q;
	assign result_value = result_q;
	assign sweeps_done  = cnt_q;
	assign capped       = capped_q;
	assign last_result  = last_q;

	// Ends take their loaded old value; interior positions use the current value.
	always_comb begin
		if (idx_q == '0) begin
			elem = old_first_q;
		end else if (idx_q == last_idx_q) begin
			elem = old_last_q;
		end else begin
			elem = rdata_q;
		end
	end

	assign sum_next = SUM_W'(cent_q) + SUM_W'(prev_q) + SUM_W'(elem);
	// Shared multiplier: one 17-bit slice of the magnitude per pass, high slice first
	assign part     = PART_W'(mag_q[SUM_W-1 -: CHUNK_W]) * PART_W'(RECIP_3);
	assign acc_next = (acc_q << CHUNK_W) + PROD_W'(part);
	assign quot     = val_t'(acc_q[PROD_W-1:RECIP_SHIFT]);
	assign after    = neg_q ? -quot : quot;
	assign change   = SUM_W'(prev_q) - SUM_W'(after_q);
	assign tol_pos  = sum_t'({{(SUM_W-TOL_W){1'b0}}, tol_q});
	assign tol_neg  = -tol_pos;
	assign cnt_next = (cnt_q != SWEEP_LIMIT) ? cnt_q + cnt_t'(1) : cnt_q;
	assign limit    = (cap_q != '0) ? cap_q : SWEEP_LIMIT;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = current_value;
		if (in_acc) begin
			mem_we = 1'b1;
		end else if (state_q == ST_FIN) begin
			mem_we    = 1'b1;
			mem_waddr = idx_q - AW'(1);
			mem_wdata = after;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			cur_mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= cur_mem[idx_q];
	end

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
			cap_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TOLERANCE: tol_q <= cfg_data[TOL_W-1:0];
				REG_SWEEP_CAP: cap_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Datapath registers without reset
	always_ff @(posedge clk) begin
		if (in_acc) begin
			if (pos_q == '0) begin
				old_first_q <= old_value;
			end
			old_last_q <= old_value;
		end
		if (state_q == ST_LATCH) begin
			sum_q  <= sum_next;
			prev_q <= cent_q;
			cent_q <= elem;
		end
		if (state_q == ST_NEG) begin
			neg_q <= sum_q[SUM_W-1];
			mag_q <= sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
			acc_q <= '0;
		end
		if (state_q == ST_DIV) begin
			mag_q <= mag_q << CHUNK_W;
			acc_q <= acc_next;
		end
		if (state_q == ST_FIN) begin
			after_q <= after;
		end
		if (state_q == ST_OUT_LD) begin
			result_q <= rdata_q;
			last_q   <= (idx_q == last_idx_q);
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			pos_q       <= '0;
			last_idx_q  <= '0;
			idx_q       <= '0;
			step_q      <= '0;
			over_q      <= 1'b0;
			cnt_q       <= '0;
			capped_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (load_final) begin
							last_idx_q <= pos_q;
							cnt_q      <= '0;
							state_q    <= ST_SW_START;
						end else begin
							pos_q <= pos_q + AW'(1);
						end
					end
				end
				ST_SW_START: begin
					idx_q  <= '0;
					over_q <= 1'b0;
					// no interior: the sweep changes nothing
					if ({1'b0, last_idx_q} < IW'(2)) begin
						state_q <= ST_SW_END;
					end else begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_LATCH;
				end
				ST_LATCH: begin
					if ({1'b0, idx_q} >= IW'(2)) begin
						state_q <= ST_NEG;
					end else begin
						idx_q   <= idx_q + AW'(1);
						state_q <= ST_RD;
					end
				end
				ST_NEG: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (change > tol_pos || change < tol_neg) begin
						over_q <= 1'b1;
					end
					if (idx_q == last_idx_q) begin
						state_q <= ST_SW_END;
					end else begin
						idx_q   <= idx_q + AW'(1);
						state_q <= ST_RD;
					end
				end
				ST_SW_END: begin
					cnt_q <= cnt_next;
					if (!over_q || cnt_next >= limit) begin
						capped_q <= over_q;
						idx_q    <= '0;
						state_q  <= ST_OUT_RD;
					end else begin
						state_q <= ST_SW_START;
					end
				end
				ST_OUT_RD: begin
					state_q <= ST_OUT_LD;
				end
				ST_OUT_LD: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_OUT_HOLD;
				end
				ST_OUT_HOLD: begin
					// hold the word until the sink takes it
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						if (idx_q == last_idx_q) begin
							pos_q   <= '0;
							state_q <= ST_LOAD;
						end else begin
							idx_q   <= idx_q + AW'(1);
							state_q <= ST_OUT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
